@@ src/rsrt_pkg.sv @@
// shared types and constants of the retransmission table
`default_nettype none

package rsrt_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_TICK = 2'd1,
    OP_ACK  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ACCEPTED    = 3'd0,
    KIND_TABLE_FULL  = 3'd1,
    KIND_RESEND_DUE  = 3'd2,
    KIND_DROPPED     = 3'd3,
    KIND_ACK_MATCHED = 3'd4,
    KIND_ACK_UNKNOWN = 3'd5,
    KIND_TICK_DONE   = 3'd6
  } kind_e;

  // configuration register indexes
  localparam logic CFG_ACK_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd5;

  // one table entry as held in memory
  typedef struct packed {
    logic [15:0] ack;
    logic [15:0] tag;
    logic [15:0] timer;
    logic [7:0]  retries;
  } entry_t;

endpackage

`default_nettype wire

@@ src/rsrt_req_if.sv @@
// request and result channel interfaces
`default_nettype none

interface rsrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] packet_tag;
  logic [15:0] ack_number;
  logic [15:0] elapsed_ticks;

  modport source (output valid, opcode, packet_tag, ack_number, elapsed_ticks, input ready);
  modport sink (input valid, opcode, packet_tag, ack_number, elapsed_ticks, output ready);
endinterface

interface rsrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] result_ack;
  logic [15:0] result_tag;
  logic        last_flag;

  modport source (output valid, result_kind, result_ack, result_tag, last_flag, input ready);
  modport sink (input valid, result_kind, result_ack, result_tag, last_flag, output ready);
endinterface

`default_nettype wire

@@ src/rsrt_mem.sv @@
// entry memory: one write port, one read port, registered read data
`default_nettype none

module rsrt_mem
  import rsrt_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/reliable_send_retry_table_unit.sv @@
// Retransmission table for reliable sends, with its sequencer and result register.
//
// Items arrive on in_i (send, tick, ack) and results leave on out_o, both with
// valid/ready; a transfer happens when both are high. Registers ack_timeout
// (index 0) and retry_limit (index 1) are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write them only while the block is idle, and the
// block itself does not enforce it. A send is answered in the cycle after its
// transfer. A tick or an ack walks the pending entries through the entry memory,
// one entry per cycle while no due entry of a tick waits on a full result
// register, compacting the table in place as entries are dropped or removed.
// The walk rate is set by the single read port of the memory and its registered
// read data. Every result of a tick also passes the one-deep result register.
// One item is processed at a time: in_i.ready is high only when the sequencer
// is idle and the result register is free or being drained.
// A stalled receiver holds the result register and pauses a tick walk at a due
// entry, with nothing lost. Reset empties the table, clears the ack id counter
// and loads the default register values; the memory itself is not cleared.
`default_nettype none

module reliable_send_retry_table_unit
  import rsrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rsrt_req_if.sink         in_i,
  rsrt_rsp_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TICK = 4'b0010,
    S_ACK  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [15:0]   ack_timeout_q;
  logic [7:0]    retry_limit_q;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   next_ack_q, next_ack_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic          is_tick_q, is_tick_d;
  logic [15:0]   elapsed_q, elapsed_d;
  logic [15:0]   ackn_q, ackn_d;
  logic          found_q, found_d;
  logic [15:0]   found_tag_q, found_tag_d;

  logic          out_valid_q;
  kind_e         out_kind_q;
  logic [15:0]   out_ack_q;
  logic [15:0]   out_tag_q;
  logic          out_last_q;

  logic          slot_free;
  logic          accept;
  logic          emit;
  kind_e         emit_kind;
  logic [15:0]   emit_ack;
  logic [15:0]   emit_tag;
  logic          emit_last;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        rdata;

  logic [16:0]   timer_sum;
  logic [15:0]   timer_new;
  logic [7:0]    retries_new;
  logic          due;
  logic          drop;
  logic          match;
  logic          last_entry;
  logic [CW-1:0] rd_next;

  rsrt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept = in_i.valid && in_i.ready;

  // per-entry update for a tick, saturating timer and retry count
  assign timer_sum   = {1'b0, rdata.timer} + {1'b0, elapsed_q};
  assign timer_new   = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
  assign due         = timer_new >= ack_timeout_q;
  assign retries_new = (rdata.retries == 8'hFF) ? 8'hFF : rdata.retries + 8'd1;
  assign drop        = due && (retries_new >= retry_limit_q);
  assign match       = !found_q && (rdata.ack == ackn_q);
  assign rd_next     = rd_q + CW'(1);
  assign last_entry  = (rd_next == count_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    next_ack_d  = next_ack_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    is_tick_d   = is_tick_q;
    elapsed_d   = elapsed_q;
    ackn_d      = ackn_q;
    found_d     = found_q;
    found_tag_d = found_tag_q;
    emit        = 1'b0;
    emit_kind   = KIND_TICK_DONE;
    emit_ack    = 16'd0;
    emit_tag    = 16'd0;
    emit_last   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr_q[AW-1:0];
    mem_wdata   = rdata;
    mem_re      = 1'b0;
    mem_raddr   = rd_next[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          elapsed_d   = in_i.elapsed_ticks;
          ackn_d      = in_i.ack_number;
          found_d     = 1'b0;
          found_tag_d = 16'd0;
          rd_d        = '0;
          wr_d        = '0;
          mem_raddr   = '0;
          unique case (op_e'(in_i.opcode)) inside
            OP_SEND: begin
              emit      = 1'b1;
              emit_last = 1'b1;
              if (count_q == FULL_COUNT) begin
                emit_kind = KIND_TABLE_FULL;
              end else begin
                emit_kind = KIND_ACCEPTED;
                emit_ack  = next_ack_q;
                emit_tag  = in_i.packet_tag;
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                mem_wdata = '{ack: next_ack_q, tag: in_i.packet_tag,
                              timer: 16'd0, retries: 8'd0};
                count_d    = count_q + CW'(1);
                next_ack_d = next_ack_q + 16'd1;
              end
            end
            OP_TICK, OP_ACK: begin
              is_tick_d = (op_e'(in_i.opcode) == OP_TICK);
              if (count_q == '0) begin
                state_d = S_DONE;
              end else begin
                mem_re  = 1'b1;
                state_d = is_tick_d ? S_TICK : S_ACK;
              end
            end
            default: ;
          endcase
        end
      end

      S_TICK: begin
        if (!due || slot_free) begin
          if (due) begin
            emit      = 1'b1;
            emit_kind = drop ? KIND_DROPPED : KIND_RESEND_DUE;
            emit_ack  = rdata.ack;
            emit_tag  = rdata.tag;
          end
          if (!drop) begin
            mem_we    = 1'b1;
            mem_wdata = '{ack: rdata.ack, tag: rdata.tag,
                          timer: due ? 16'd0 : timer_new,
                          retries: due ? retries_new : rdata.retries};
            wr_d      = wr_q + CW'(1);
          end
          if (last_entry) begin
            state_d = S_DONE;
          end else begin
            mem_re = 1'b1;
            rd_d   = rd_next;
          end
        end
      end

      S_ACK: begin
        if (match) begin
          found_d     = 1'b1;
          found_tag_d = rdata.tag;
        end else begin
          mem_we = 1'b1;
          wr_d   = wr_q + CW'(1);
        end
        if (last_entry) begin
          state_d = S_DONE;
        end else begin
          mem_re = 1'b1;
          rd_d   = rd_next;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (is_tick_q) begin
            emit_kind = KIND_TICK_DONE;
          end else begin
            emit_kind = found_q ? KIND_ACK_MATCHED : KIND_ACK_UNKNOWN;
            emit_ack  = ackn_q;
            emit_tag  = found_tag_q;
          end
          count_d = wr_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_ack_q  <= 16'd0;
      rd_q        <= '0;
      wr_q        <= '0;
      is_tick_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_ack_q <= next_ack_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      is_tick_q <= is_tick_d;
      found_q   <= found_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and result register
  always_ff @(posedge clk_i) begin
    elapsed_q   <= elapsed_d;
    ackn_q      <= ackn_d;
    found_tag_q <= found_tag_d;
    if (emit) begin
      out_kind_q <= emit_kind;
      out_ack_q  <= emit_ack;
      out_tag_q  <= emit_tag;
      out_last_q <= emit_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.result_ack  = out_ack_q;
  assign out_o.result_tag  = out_tag_q;
  assign out_o.last_flag   = out_last_q;

endmodule

`default_nettype wire
